// ===== rtl/core/bcr_pkg.sv =====
// Shared types and constants for the branch and CR logic unit.
package bcr_pkg;

   localparam logic [3:0] OP_B      = 4'd0;
   localparam logic [3:0] OP_BC     = 4'd1;
   localparam logic [3:0] OP_BCLR   = 4'd2;
   localparam logic [3:0] OP_BCCTR  = 4'd3;
   localparam logic [3:0] OP_SC     = 4'd4;
   localparam logic [3:0] OP_CRAND  = 4'd5;
   localparam logic [3:0] OP_CROR   = 4'd6;
   localparam logic [3:0] OP_CRXOR  = 4'd7;
   localparam logic [3:0] OP_CRNAND = 4'd8;
   localparam logic [3:0] OP_CRNOR  = 4'd9;
   localparam logic [3:0] OP_CREQV  = 4'd10;
   localparam logic [3:0] OP_CRANDC = 4'd11;
   localparam logic [3:0] OP_CRORC  = 4'd12;
   localparam logic [3:0] OP_MCRF   = 4'd13;
   localparam logic [3:0] OP_ISYNC  = 4'd14;

   // BO bit positions (LSB numbering of the 5-bit field)
   localparam int BO_NO_COND  = 4;
   localparam int BO_COND_VAL = 3;
   localparam int BO_NO_DEC   = 2;
   localparam int BO_CTR_ZERO = 1;

   localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;
   localparam logic [31:0] LINK_STEP  = 32'd4;

   typedef struct packed {
      logic [3:0]  operation;
      logic [31:0] instruction;
      logic [31:0] pc;
      logic [31:0] cr;
      logic [31:0] ctr;
      logic [31:0] lr;
   } bcr_item_type;

   typedef struct packed {
      logic        redirect;
      logic [31:0] target;
      logic [31:0] ctr;
      logic [31:0] lr;
   } bcr_branch_res_type;

endpackage

// ===== rtl/core/bcr_branch.sv =====
// Branch evaluation: target, BO tests, CTR decrement and link write.
module bcr_branch (
   input  bcr_pkg::bcr_item_type       item,
   output bcr_pkg::bcr_branch_res_type res
);
   import bcr_pkg::*;

   logic [4:0]  bo;
   logic [4:0]  bi;
   logic        aa;
   logic        lk;
   logic        cond_ok;
   logic        ctr_ok;
   logic [31:0] ctr_dec;
   logic [31:0] disp;
   logic [31:0] rel_target;
   logic [31:0] link;
   logic        taken;
   logic [31:0] target_sel;

   assign bo = item.instruction[25:21];
   assign bi = item.instruction[20:16];
   assign aa = item.instruction[1];
   assign lk = item.instruction[0];

   // CR bit 0 is the MSB, so bit n sits at index 31-n, i.e. ~n
   assign cond_ok = bo[BO_NO_COND] | (item.cr[~bi] == bo[BO_COND_VAL]);
   assign ctr_dec = item.ctr - 32'd1;
   assign ctr_ok  = bo[BO_NO_DEC] | ((ctr_dec != 32'd0) ^ bo[BO_CTR_ZERO]);

   assign disp = (item.operation == OP_B)
               ? {{6{item.instruction[25]}}, item.instruction[25:2], 2'b00}
               : {{16{item.instruction[15]}}, item.instruction[15:2], 2'b00};
   assign rel_target = aa ? disp : item.pc + disp;
   assign link       = item.pc + LINK_STEP;

   always_comb begin
      res.ctr    = item.ctr;
      res.lr     = item.lr;
      taken      = 1'b0;
      target_sel = rel_target;
      case (item.operation)
         OP_B: begin
            taken = 1'b1;
            if (lk) res.lr = link;
         end
         OP_BC: begin
            taken = ctr_ok & cond_ok;
            if (!bo[BO_NO_DEC]) res.ctr = ctr_dec;
            if (lk) res.lr = link;
         end
         OP_BCLR: begin
            taken      = ctr_ok & cond_ok;
            target_sel = item.lr & ALIGN_MASK;
            if (!bo[BO_NO_DEC]) res.ctr = ctr_dec;
            if (lk) res.lr = link;
         end
         OP_BCCTR: begin
            taken      = cond_ok;
            target_sel = item.ctr & ALIGN_MASK;
            if (lk) res.lr = link;
         end
         default: begin
            taken = 1'b0;
         end
      endcase
      res.redirect = taken;
      res.target   = taken ? target_sel : 32'd0;
   end

endmodule

// ===== rtl/core/bcr_crlogic.sv =====
// CR-bit logical operations and mcrf.
module bcr_crlogic (
   input  bcr_pkg::bcr_item_type item,
   output logic [31:0]           cr_out
);
   import bcr_pkg::*;

   logic       bit_a;
   logic       bit_b;
   logic       bit_r;
   logic [4:0] bit_d;
   logic [2:0] fld_d;
   logic [2:0] fld_s;
   logic [3:0] fld_val;

   assign bit_a   = item.cr[~item.instruction[20:16]];
   assign bit_b   = item.cr[~item.instruction[15:11]];
   assign bit_d   = ~item.instruction[25:21];
   assign fld_d   = item.instruction[25:23];
   assign fld_s   = item.instruction[20:18];
   // field f spans CR bits 4f..4f+3, low index 4*(7-f)
   assign fld_val = item.cr[{~fld_s, 2'b00} +: 4];

   always_comb begin
      case (item.operation)
         OP_CRAND:  bit_r = bit_a & bit_b;
         OP_CROR:   bit_r = bit_a | bit_b;
         OP_CRXOR:  bit_r = bit_a ^ bit_b;
         OP_CRNAND: bit_r = ~(bit_a & bit_b);
         OP_CRNOR:  bit_r = ~(bit_a | bit_b);
         OP_CREQV:  bit_r = ~(bit_a ^ bit_b);
         OP_CRANDC: bit_r = bit_a & ~bit_b;
         default:   bit_r = bit_a | ~bit_b;
      endcase
   end

   always_comb begin
      cr_out = item.cr;
      case (item.operation)
         OP_CRAND, OP_CROR, OP_CRXOR, OP_CRNAND,
         OP_CRNOR, OP_CREQV, OP_CRANDC, OP_CRORC: begin
            cr_out[bit_d] = bit_r;
         end
         OP_MCRF: begin
            cr_out[{~fld_d, 2'b00} +: 4] = fld_val;
         end
         default: begin
            cr_out = item.cr;
         end
      endcase
   end

endmodule

// ===== rtl/core/ppc_branch_cr_unit.sv =====
// Top level of the branch and CR logic unit: input stage, evaluation, result stage.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  operation, instruction, pc, cr/ctr/lr in
//   rsp      out        rsp_valid/rsp_stall  redirect, target, cr/ctr/lr out, syscall
//
// One transaction per cycle while rsp is not stalled; a request passes the input register,
// then the result register after one pass of decode, add and decrement.
// Synchronous reset clears only the two valid flags.
// A stall on rsp holds the result register; req stalls only when both stages are full.
module ppc_branch_cr_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_cr_in,
   input  logic [31:0] req_ctr_in,
   input  logic [31:0] req_lr_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_redirect,
   output logic [31:0] rsp_branch_target,
   output logic [31:0] rsp_cr_out,
   output logic [31:0] rsp_ctr_out,
   output logic [31:0] rsp_lr_out,
   output logic        rsp_syscall_raised
);
   import bcr_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   bcr_item_type       s1_item_ff;
   logic               out_valid_ff, out_valid_in;
   bcr_branch_res_type out_br_ff;
   logic [31:0]        out_cr_ff;
   logic               out_sys_ff;
   logic               out_ready;
   bcr_branch_res_type br_res;
   logic [31:0]        cr_res;

   assign out_ready = ~out_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~out_ready;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_item_ff.operation   <= req_operation;
         s1_item_ff.instruction <= req_instruction;
         s1_item_ff.pc          <= req_pc;
         s1_item_ff.cr          <= req_cr_in;
         s1_item_ff.ctr         <= req_ctr_in;
         s1_item_ff.lr          <= req_lr_in;
      end
   end

   bcr_branch u_branch (
      .item (s1_item_ff),
      .res  (br_res)
   );

   bcr_crlogic u_crlogic (
      .item   (s1_item_ff),
      .cr_out (cr_res)
   );

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         out_br_ff  <= br_res;
         out_cr_ff  <= cr_res;
         out_sys_ff <= (s1_item_ff.operation == OP_SC);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_redirect       = out_br_ff.redirect;
   assign rsp_branch_target  = out_br_ff.target;
   assign rsp_cr_out         = out_cr_ff;
   assign rsp_ctr_out        = out_br_ff.ctr;
   assign rsp_lr_out         = out_br_ff.lr;
   assign rsp_syscall_raised = out_sys_ff;

endmodule

// ===== rtl/core/bcr_checker.sv =====
// Port-level checks for the branch and CR logic unit, bound to the top level.
module bcr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_redirect,
   input logic [31:0] rsp_branch_target,
   input logic        rsp_syscall_raised
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_branch_target)
         && $stable(rsp_redirect) && $stable(rsp_syscall_raised))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // backpressure only arises from a full result stage
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty result stage");

   a_not_taken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_redirect |-> rsp_branch_target == 32'd0)
      else $error("target nonzero on a transaction without redirect");

   a_sc_no_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_syscall_raised |-> !rsp_redirect)
      else $error("sc transaction also redirected");

endmodule

bind ppc_branch_cr_unit bcr_checker u_bcr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_redirect       (rsp_redirect),
   .rsp_branch_target  (rsp_branch_target),
   .rsp_syscall_raised (rsp_syscall_raised)
);
